FILE: rtl/edq_pkg.sv
// ----------------------------------------------------------------------------
// edq_pkg - shared types and codes
// Opcodes, status codes, the stored record layout and the sequencer states.
// ----------------------------------------------------------------------------
package edq_pkg;

	typedef enum logic [1:0] {
		OP_TAIL    = 2'd0,
		OP_HEAD    = 2'd1,
		OP_DEQ     = 2'd2,
		OP_DEQ_ALT = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ENQ   = 3'd0,
		ST_EVICT = 3'd1,
		ST_FULL  = 3'd2,
		ST_DEQ   = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] event_type;
		logic [31:0] event_data;
		logic [31:0] free_data;
	} rec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_UNLINK,
		S_LINK,
		S_FIX,
		S_DEQ,
		S_OUT
	} state_t;

endpackage

FILE: rtl/edq_in_if.sv
// ----------------------------------------------------------------------------
// edq_in_if - request channel
// Valid/ready channel carrying one queue operation per item.
// ----------------------------------------------------------------------------
interface edq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] event_type;
	logic [31:0] event_data;
	logic [31:0] free_data;

	modport source (output valid, opcode, event_type, event_data, free_data, input ready);
	modport sink   (input valid, opcode, event_type, event_data, free_data, output ready);
endinterface

FILE: rtl/edq_out_if.sv
// ----------------------------------------------------------------------------
// edq_out_if - result channel
// Valid/ready channel carrying one result item per operation.
// ----------------------------------------------------------------------------
interface edq_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] out_type;
	logic [31:0] out_data;
	logic [31:0] out_free_data;
	logic [6:0]  occupancy;

	modport source (output valid, status, out_type, out_data, out_free_data, occupancy,
		input ready);
	modport sink   (input valid, status, out_type, out_data, out_free_data, occupancy,
		output ready);
endinterface

FILE: rtl/event_deque_with_discard_eviction.sv
// ----------------------------------------------------------------------------
// event_deque_with_discard_eviction - bounded event deque
// Linked-list event queue in on-chip memory with discard eviction when full.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one item is an operation (enqueue at tail, enqueue at head,
//    dequeue). Opcode three acts as a dequeue.
//  - rsp channel: exactly one result item per request, in order, holding
//    status, the dequeued or evicted record (zero otherwise) and occupancy.
//  - cfg_we/cfg_wdata write discard_mask; write only while the block is idle.
// Steps per item, from accept up to the result register load:
//  - enqueue into a free slot: accept, link, fix neighbor, out
//  - dequeue: accept, dequeue, out; dequeue from empty: accept, out
//  - enqueue when full: accept, a walk visiting one record per cycle from
//    the head up to CAPACITY, then unlink, link, fix, out; if rejected, out
//  The walk is set by the registered read of the link memory: each next
//  pointer read feeds the next read address.
// A new request is taken once the previous result sits in the output
// register; a stalled receiver leaves one result there and one finished item
// waiting behind it, and the request side then stalls.
// Reset empties the queue at once; slot contents need no clearing since
// unused slots are handed out by a fill counter once the free chain is empty.
// ----------------------------------------------------------------------------
module event_deque_with_discard_eviction
	import edq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	edq_in_if.sink      req,
	edq_out_if.source   rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// slot index width, and pointer width with room for the null code
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW = $clog2(CAPACITY + 1);

	logic [AW-1:0] rd_addr;
	rec_t          rd_rec;
	logic [SW-1:0] rd_next, rd_prev;
	logic          rec_we, nx_we, pv_we;
	logic [AW-1:0] rec_waddr, nx_waddr, pv_waddr;
	rec_t          rec_wdata;
	logic [SW-1:0] nx_wdata, pv_wdata;

	// sequencer: pointers, walk and output register
	edq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.SW       (SW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rd_addr   (rd_addr),
		.rd_rec    (rd_rec),
		.rd_next   (rd_next),
		.rd_prev   (rd_prev),
		.rec_we    (rec_we),
		.rec_waddr (rec_waddr),
		.rec_wdata (rec_wdata),
		.nx_we     (nx_we),
		.nx_waddr  (nx_waddr),
		.nx_wdata  (nx_wdata),
		.pv_we     (pv_we),
		.pv_waddr  (pv_waddr),
		.pv_wdata  (pv_wdata)
	);

	// record store plus forward and backward links
	edq_store #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.SW       (SW)
	) u_store (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.rd_rec    (rd_rec),
		.rd_next   (rd_next),
		.rd_prev   (rd_prev),
		.rec_we    (rec_we),
		.rec_waddr (rec_waddr),
		.rec_wdata (rec_wdata),
		.nx_we     (nx_we),
		.nx_waddr  (nx_waddr),
		.nx_wdata  (nx_wdata),
		.pv_we     (pv_we),
		.pv_waddr  (pv_waddr),
		.pv_wdata  (pv_wdata)
	);

endmodule

FILE: rtl/edq_store.sv
// ----------------------------------------------------------------------------
// edq_store - record and link memories
// Three single-write memories sharing one read address, with registered read data.
// ----------------------------------------------------------------------------
module edq_store
	import edq_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int AW = 6,
	parameter int SW = 7
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output rec_t          rd_rec,
	output logic [SW-1:0] rd_next,
	output logic [SW-1:0] rd_prev,
	input  logic          rec_we,
	input  logic [AW-1:0] rec_waddr,
	input  rec_t          rec_wdata,
	input  logic          nx_we,
	input  logic [AW-1:0] nx_waddr,
	input  logic [SW-1:0] nx_wdata,
	input  logic          pv_we,
	input  logic [AW-1:0] pv_waddr,
	input  logic [SW-1:0] pv_wdata
);

	rec_t          rec_mem [CAPACITY];
	logic [SW-1:0] nx_mem  [CAPACITY];
	logic [SW-1:0] pv_mem  [CAPACITY];

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rd_rec <= rec_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			nx_mem[nx_waddr] <= nx_wdata;
		end
		rd_next <= nx_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			pv_mem[pv_waddr] <= pv_wdata;
		end
		rd_prev <= pv_mem[rd_addr];
	end

endmodule

FILE: rtl/edq_ctrl.sv
// ----------------------------------------------------------------------------
// edq_ctrl - list sequencer
// Head/tail/free pointers, eviction walk, link updates and result register.
// ----------------------------------------------------------------------------
module edq_ctrl
	import edq_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int AW = 6,
	parameter int SW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	edq_in_if.sink        req,
	edq_out_if.source     rsp,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	output logic [AW-1:0] rd_addr,
	input  rec_t          rd_rec,
	input  logic [SW-1:0] rd_next,
	input  logic [SW-1:0] rd_prev,
	output logic          rec_we,
	output logic [AW-1:0] rec_waddr,
	output rec_t          rec_wdata,
	output logic          nx_we,
	output logic [AW-1:0] nx_waddr,
	output logic [SW-1:0] nx_wdata,
	output logic          pv_we,
	output logic [AW-1:0] pv_waddr,
	output logic [SW-1:0] pv_wdata
);

	localparam logic [SW-1:0] NIL = SW'(CAPACITY);

	state_t        state_q, state_d;
	logic [SW-1:0] head_q, tail_q, free_q, cur_q, p_q, n_q, alloc_q, count_q;
	logic          front_q, from_free_q;
	rec_t          rec_q, res_rec_q;
	status_t       res_st_q;
	logic [31:0]   mask_q;
	logic          out_v_q;

	logic is_deq, has_free, has_fresh, hit, out_free;

	assign is_deq    = (req.opcode == OP_DEQ) || (req.opcode == OP_DEQ_ALT);
	assign has_free  = (free_q != NIL);
	assign has_fresh = (alloc_q != NIL);
	assign hit       = ((rd_rec.event_type & mask_q) != 32'd0);
	assign out_free  = !out_v_q || rsp.ready;

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_v_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (is_deq) begin
						state_d = (head_q == NIL) ? S_OUT : S_DEQ;
					end else if (has_free || has_fresh) begin
						state_d = S_LINK;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (hit) begin
					state_d = S_UNLINK;
				end else if (rd_next == NIL) begin
					state_d = S_OUT;
				end
			end
			S_UNLINK: state_d = S_LINK;
			S_LINK:   state_d = S_FIX;
			S_FIX:    state_d = S_OUT;
			S_DEQ:    state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// memory requests
	always_comb begin
		rd_addr   = head_q[AW-1:0];
		rec_we    = 1'b0;
		rec_waddr = cur_q[AW-1:0];
		rec_wdata = rec_q;
		nx_we     = 1'b0;
		nx_waddr  = cur_q[AW-1:0];
		nx_wdata  = NIL;
		pv_we     = 1'b0;
		pv_waddr  = cur_q[AW-1:0];
		pv_wdata  = NIL;
		unique case (state_q)
			S_IDLE: begin
				if (!is_deq && has_free) begin
					rd_addr = free_q[AW-1:0];
				end
			end
			S_WALK: rd_addr = rd_next[AW-1:0];
			S_UNLINK: begin
				nx_we    = (p_q != NIL);
				nx_waddr = p_q[AW-1:0];
				nx_wdata = n_q;
				pv_we    = (n_q != NIL);
				pv_waddr = n_q[AW-1:0];
				pv_wdata = p_q;
			end
			S_LINK: begin
				rec_we   = 1'b1;
				nx_we    = 1'b1;
				nx_wdata = front_q ? head_q : NIL;
				pv_we    = 1'b1;
				pv_wdata = front_q ? NIL : tail_q;
			end
			S_FIX: begin
				pv_we    = front_q && (head_q != NIL);
				pv_waddr = head_q[AW-1:0];
				pv_wdata = cur_q;
				nx_we    = !front_q && (tail_q != NIL);
				nx_waddr = tail_q[AW-1:0];
				nx_wdata = cur_q;
			end
			S_DEQ: begin
				nx_we    = 1'b1;
				nx_wdata = free_q;
				pv_we    = (rd_next != NIL);
				pv_waddr = rd_next[AW-1:0];
				pv_wdata = NIL;
			end
			S_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NIL;
			tail_q      <= NIL;
			free_q      <= NIL;
			alloc_q     <= '0;
			count_q     <= '0;
			cur_q       <= NIL;
			p_q         <= NIL;
			n_q         <= NIL;
			front_q     <= 1'b0;
			from_free_q <= 1'b0;
			res_st_q    <= ST_ENQ;
			mask_q      <= 32'h8000_0000;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			// result register: loaded from S_OUT, cleared when taken
			if (state_q == S_OUT && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						front_q <= (req.opcode == OP_HEAD);
						if (is_deq) begin
							res_st_q    <= ST_EMPTY;
							cur_q       <= head_q;
							from_free_q <= 1'b0;
						end else if (has_free) begin
							res_st_q    <= ST_ENQ;
							cur_q       <= free_q;
							from_free_q <= 1'b1;
							count_q     <= count_q + 1'b1;
						end else if (has_fresh) begin
							res_st_q    <= ST_ENQ;
							cur_q       <= alloc_q;
							from_free_q <= 1'b0;
							alloc_q     <= alloc_q + 1'b1;
							count_q     <= count_q + 1'b1;
						end else begin
							res_st_q    <= ST_ENQ;
							cur_q       <= head_q;
							from_free_q <= 1'b0;
						end
					end
				end
				S_WALK: begin
					if (hit) begin
						res_st_q <= ST_EVICT;
						p_q      <= rd_prev;
						n_q      <= rd_next;
					end else if (rd_next == NIL) begin
						res_st_q <= ST_FULL;
					end else begin
						cur_q <= rd_next;
					end
				end
				S_UNLINK: begin
					if (p_q == NIL) begin
						head_q <= n_q;
					end
					if (n_q == NIL) begin
						tail_q <= p_q;
					end
				end
				S_LINK: begin
					if (from_free_q) begin
						free_q <= rd_next;
					end
				end
				S_FIX: begin
					if (front_q) begin
						if (head_q == NIL) begin
							tail_q <= cur_q;
						end
						head_q <= cur_q;
					end else begin
						if (tail_q == NIL) begin
							head_q <= cur_q;
						end
						tail_q <= cur_q;
					end
				end
				S_DEQ: begin
					head_q   <= rd_next;
					if (rd_next == NIL) begin
						tail_q <= NIL;
					end
					free_q   <= cur_q;
					count_q  <= count_q - 1'b1;
					res_st_q <= ST_DEQ;
				end
				S_OUT: ;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			rec_q     <= '{req.event_type, req.event_data, req.free_data};
			res_rec_q <= '0;
		end
		if (state_q == S_WALK && hit) begin
			res_rec_q <= rd_rec;
		end
		if (state_q == S_DEQ) begin
			res_rec_q <= rd_rec;
		end
		if (state_q == S_OUT && out_free) begin
			rsp.status        <= res_st_q;
			rsp.out_type      <= res_rec_q.event_type;
			rsp.out_data      <= res_rec_q.event_data;
			rsp.out_free_data <= res_rec_q.free_data;
			rsp.occupancy     <= 7'(count_q);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL) else $error("held count above capacity");
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UNLINK |-> count_q == NIL) else $error("eviction with room left");
	// free_q still names the slot being taken while in S_LINK
	a_free_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LINK && free_q != NIL) |-> count_q < NIL)
		else $error("free chain while full");
	a_ends_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (head_q == NIL) == (tail_q == NIL))
		else $error("head and tail disagree on empty");
`endif

endmodule
